/* hw/rtl/esp3d_pkg.sv */
// Shared types, constants and helper functions for the serial packet deframer.
// Used by esp3d_parser and esp3_packet_deframer_core; depends on nothing else.
`default_nettype none

package esp3d_pkg;

    // Byte values with a fixed meaning on the link.
    localparam logic [7:0] SyncByte = 8'h55;
    localparam logic [7:0] CrcPoly  = 8'h07;
    localparam logic [7:0] CharCr   = 8'd13;
    localparam logic [7:0] CharLf   = 8'd10;

    // A good header produces the longest burst: six bytes as hex pairs.
    localparam int HdrBytes = 6;
    localparam int JobChars = 2 * HdrBytes;
    localparam int CntW     = $clog2(JobChars + 1);

    // Frame length counters.
    localparam int LenW = 17;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int AddrW = 3;
    localparam int DataW = 32;
    localparam logic RegBinaryMode = 1'b0;

    // The burst of characters that one received byte gives rise to.
    typedef struct packed {
        logic [CntW-1:0]          cnt;
        logic [JobChars-1:0][7:0] chars;
        logic                     char_valid;
        logic                     eom;
    } job_t;

    // One CRC-8 byte step, polynomial 0x07, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CrcPoly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Upper-case hex ASCII digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = 8'h30 + {4'h0, nib};
        else
            r = 8'h37 + {4'h0, nib};
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/esp3d_parser.sv */
// Frame state machine: sync hunt, header capture and check, payload count.
// Depends on esp3d_pkg; gives the character burst for the byte at its input.
`default_nettype none

module esp3d_parser
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           binary_mode,
    input  wire logic [7:0]     rx_byte,
    output esp3d_pkg::job_t     job
);

    import esp3d_pkg::*;

    localparam logic [2:0] ST_SYNC    = 3'd0;
    localparam logic [2:0] ST_LEN_H   = 3'd1;
    localparam logic [2:0] ST_LEN_L   = 3'd2;
    localparam logic [2:0] ST_OPT     = 3'd3;
    localparam logic [2:0] ST_TYPE    = 3'd4;
    localparam logic [2:0] ST_CHECK   = 3'd5;
    localparam logic [2:0] ST_PAYLOAD = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [7:0]      len_h_reg, len_h_next;
    logic [7:0]      len_l_reg, len_l_next;
    logic [7:0]      opt_reg,   opt_next;
    logic [7:0]      type_reg,  type_next;
    logic [7:0]      chk_reg,   chk_next;
    logic [LenW-1:0] rcv_reg,   rcv_next;
    logic [LenW-1:0] exp_reg,   exp_next;

    logic [7:0]      crc;
    logic [LenW-1:0] rcv_inc;
    logic            last;
    logic [HdrBytes-1:0][7:0] hdr;

    // Header check over the four buffered header bytes.
    assign crc = crc8_step(crc8_step(crc8_step(crc8_step(8'h00, len_h_reg), len_l_reg),
                                     opt_reg), type_reg);

    // Payload counting: the frame ends after data, optional data and check byte.
    assign rcv_inc = rcv_reg + LenW'(1);
    assign last    = {1'b0, rcv_inc} >= ({1'b0, exp_reg} + (LenW+1)'(1));

    assign hdr = {rx_byte, type_reg, opt_reg, len_l_reg, len_h_reg, SyncByte};

    // Next state and the burst of characters for this byte.
    always_comb
    begin
        state_next = state_reg;
        len_h_next = len_h_reg;
        len_l_next = len_l_reg;
        opt_next   = opt_reg;
        type_next  = type_reg;
        chk_next   = chk_reg;
        rcv_next   = rcv_reg;
        exp_next   = exp_reg;
        job        = '0;

        if (!binary_mode)
        begin
            // Line mode: carriage return dropped, line feed ends the line.
            if (rx_byte == CharLf)
            begin
                job.cnt = CntW'(1);
                job.eom = 1'b1;
            end
            else if (rx_byte != CharCr)
            begin
                job.cnt        = CntW'(1);
                job.chars[0]   = rx_byte;
                job.char_valid = 1'b1;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_LEN_H:
                begin
                    len_h_next = rx_byte;
                    state_next = ST_LEN_L;
                end
                ST_LEN_L:
                begin
                    len_l_next = rx_byte;
                    state_next = ST_OPT;
                end
                ST_OPT:
                begin
                    opt_next   = rx_byte;
                    state_next = ST_TYPE;
                end
                ST_TYPE:
                begin
                    type_next  = rx_byte;
                    state_next = ST_CHECK;
                end
                ST_CHECK:
                begin
                    chk_next = rx_byte;
                    if (crc == rx_byte)
                    begin
                        // Good header: all six header bytes go out as hex pairs.
                        job.cnt        = CntW'(JobChars);
                        job.char_valid = 1'b1;
                        for (int i = 0; i < HdrBytes; i++)
                        begin
                            job.chars[2*i]   = hex_char(hdr[i][7:4]);
                            job.chars[2*i+1] = hex_char(hdr[i][3:0]);
                        end
                        rcv_next   = '0;
                        exp_next   = {1'b0, len_h_reg, len_l_reg} + {9'h000, opt_reg};
                        state_next = ST_PAYLOAD;
                    end
                    // Bad header: resynchronise on the earliest buffered sync byte.
                    else if (len_h_reg == SyncByte)
                    begin
                        len_h_next = len_l_reg;
                        len_l_next = opt_reg;
                        opt_next   = type_reg;
                        type_next  = rx_byte;
                        state_next = ST_CHECK;
                    end
                    else if (len_l_reg == SyncByte)
                    begin
                        len_h_next = opt_reg;
                        len_l_next = type_reg;
                        opt_next   = rx_byte;
                        state_next = ST_TYPE;
                    end
                    else if (opt_reg == SyncByte)
                    begin
                        len_h_next = type_reg;
                        len_l_next = rx_byte;
                        state_next = ST_OPT;
                    end
                    else if (type_reg == SyncByte)
                    begin
                        len_h_next = rx_byte;
                        state_next = ST_LEN_L;
                    end
                    else if (rx_byte == SyncByte)
                        state_next = ST_LEN_H;
                    else
                        state_next = ST_SYNC;
                end
                ST_PAYLOAD:
                begin
                    rcv_next       = rcv_inc;
                    job.cnt        = CntW'(2);
                    job.char_valid = 1'b1;
                    job.eom        = last;
                    job.chars[0]   = hex_char(rx_byte[7:4]);
                    job.chars[1]   = hex_char(rx_byte[3:0]);
                    if (last)
                        state_next = ST_SYNC;
                end
                default:
                begin
                    // Sync hunt, and the unused code which behaves the same.
                    if (rx_byte == SyncByte)
                        state_next = ST_LEN_H;
                    else
                        state_next = ST_SYNC;
                end
            endcase
        end
    end

    // Framing state only moves on binary-mode bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC;
            len_h_reg <= '0;
            len_l_reg <= '0;
            opt_reg   <= '0;
            type_reg  <= '0;
            chk_reg   <= '0;
            rcv_reg   <= '0;
            exp_reg   <= '0;
        end
        else if (step && binary_mode)
        begin
            state_reg <= state_next;
            len_h_reg <= len_h_next;
            len_l_reg <= len_l_next;
            opt_reg   <= opt_next;
            type_reg  <= type_next;
            chk_reg   <= chk_next;
            rcv_reg   <= rcv_next;
            exp_reg   <= exp_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/esp3_packet_deframer_core.sv */
// A byte waits in the input register until its burst moves into the result register.
// Throughput: one byte per ready cycle when it gives at most one character, otherwise one
// byte per burst; a good header gives twelve characters and a payload byte two.
// The result register drains one character per ready cycle and overlaps the next byte.
// Reset (rst_n, asynchronous, active low): sync hunt, binary mode, buffers empty.
`default_nettype none

module esp3_packet_deframer_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Receive stream.
    input  wire logic                         s_axis_tvalid,
    output wire logic                         s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    // Character stream.
    output wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output wire logic [7:0]                   m_axis_tdata,   // [7:0] out_char
    output wire logic                         m_axis_tuser,   // [0] char_valid
    output wire logic                         m_axis_tlast,   // end_of_message
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [esp3d_pkg::AddrW-1:0]  paddr,
    input  wire logic [esp3d_pkg::DataW-1:0]  pwdata,
    output wire logic [esp3d_pkg::DataW-1:0]  prdata,
    output wire logic                         pready
);

    import esp3d_pkg::*;

    logic                     mode_reg;
    logic                     in_vld_reg;
    logic [7:0]               in_byte_reg;
    logic [CntW-1:0]          cnt_reg;
    logic [JobChars-1:0][7:0] chars_reg;
    logic                     cval_reg;
    logic                     eom_reg;

    logic  out_free;
    logic  adv;
    logic  pop;
    logic  cfg_wr;
    job_t  job;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegBinaryMode);
    assign prdata = (paddr[2] == RegBinaryMode) ? {{(DataW-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_wr)
            mode_reg <= pwdata[0];
    end

    // Handshake: the input register moves on as the result register frees up.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign out_free      = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_axis_tready);
    assign adv           = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_vld_reg <= 1'b1;
        else if (adv)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    esp3d_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .binary_mode (mode_reg),
        .rx_byte     (in_byte_reg),
        .job         (job)
    );

    // Result register: loaded whole with the burst, shifted out one character per ready cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (adv)
            cnt_reg <= job.cnt;
        else if (pop)
            cnt_reg <= cnt_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chars_reg <= job.chars;
            cval_reg  <= job.char_valid;
            eom_reg   <= job.eom;
        end
        else if (pop)
            chars_reg <= {8'h00, chars_reg[JobChars-1:1]};
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = chars_reg[0];
    assign m_axis_tuser  = cval_reg;
    assign m_axis_tlast  = eom_reg && (cnt_reg == CntW'(1));

    // The burst never runs past the longest one.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(JobChars))
        else $error("character count beyond burst length");

    // Taking a character that is not the last of its burst leaves the next one shown.
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (cnt_reg > CntW'(1)) |=> m_axis_tvalid)
        else $error("burst broke off early");

    // Only the line-end marker carries no character, and it always ends a message.
    a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty item that does not end a message");

    // A byte waiting in the input register moves on whenever the burst is done.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && (cnt_reg == '0) |-> s_axis_tready)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

/* dv/esp3_packet_deframer_core_tb.sv */
// Self-checking testbench for esp3_packet_deframer_core: byte stream in, hex or raw characters out.
// Depends on esp3d_pkg and the core RTL; a built-in deframer model predicts every character.
`default_nettype none

module esp3_packet_deframer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import esp3d_pkg::*;

    // Register map and run limits.
    localparam logic [AddrW-1:0] AddrMode  = 3'd0;
    localparam logic [AddrW-1:0] AddrSpare = 3'd4;
    localparam int CycleLimit  = 400000;
    localparam int SettleTicks = 6;
    localparam int MaxPrinted  = 30;

    // Framing states of the model.
    typedef enum logic [2:0]
    {
        FsSync,
        FsLenH,
        FsLenL,
        FsOpt,
        FsType,
        FsCheck,
        FsPayload
    } frame_state_t;

    // One expected character transaction.
    typedef struct packed
    {
        logic [7:0] ch;
        logic       valid;
        logic       eom;
    } char_item_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [AddrW-1:0]     paddr         = '0;
    logic [DataW-1:0]     pwdata        = '0;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    // Model state and the characters still owed by the block.
    logic                 mdl_binary;
    frame_state_t         fs;
    logic [7:0]           hdr_len_h;
    logic [7:0]           hdr_len_l;
    logic [7:0]           hdr_opt;
    logic [7:0]           hdr_type;
    logic [7:0]           hdr_crc;
    logic [16:0]          payload_seen;
    logic [16:0]          payload_due;
    char_item_t           pending_chars[$];
    char_item_t           want;

    int                   src_idle_pct   = 0;
    int                   sink_stall_pct = 0;
    int                   sent_items     = 0;
    int                   mismatches     = 0;
    int                   cycle_count    = 0;

    esp3_packet_deframer_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // One line per mismatch; printing stops after a while but counting does not.
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                     exp_val);
    endtask

    // CRC-8 with polynomial 0x07 over one byte.
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] c;
        c = acc ^ d;
        for (int k = 0; k < 8; k++)
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic logic [7:0] header_crc(input logic [7:0] h, input logic [7:0] l,
                                              input logic [7:0] o, input logic [7:0] t);
        return crc8_next(crc8_next(crc8_next(crc8_next(8'h00, h), l), o), t);
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    task automatic owe_char(input logic [7:0] ch, input logic valid, input logic eom);
        pending_chars.push_back('{ch: ch, valid: valid, eom: eom});
    endtask

    task automatic owe_hex_pair(input logic [7:0] b, input logic last);
        owe_char(hex_ascii(b[7:4]), 1'b1, 1'b0);
        owe_char(hex_ascii(b[3:0]), 1'b1, last);
    endtask

    // Header check: either the whole header goes out as hex, or the machine
    // resynchronises on the earliest sync byte held in the buffer.
    task automatic judge_header();
        if (header_crc(hdr_len_h, hdr_len_l, hdr_opt, hdr_type) == hdr_crc)
        begin
            owe_hex_pair(SyncByte, 1'b0);
            owe_hex_pair(hdr_len_h, 1'b0);
            owe_hex_pair(hdr_len_l, 1'b0);
            owe_hex_pair(hdr_opt, 1'b0);
            owe_hex_pair(hdr_type, 1'b0);
            owe_hex_pair(hdr_crc, 1'b0);
            payload_seen = '0;
            payload_due  = {1'b0, hdr_len_h, hdr_len_l} + {9'd0, hdr_opt};
            fs           = FsPayload;
        end
        else if (hdr_len_h == SyncByte)
        begin
            hdr_len_h = hdr_len_l;
            hdr_len_l = hdr_opt;
            hdr_opt   = hdr_type;
            hdr_type  = hdr_crc;
            fs        = FsCheck;
        end
        else if (hdr_len_l == SyncByte)
        begin
            hdr_len_h = hdr_opt;
            hdr_len_l = hdr_type;
            hdr_opt   = hdr_crc;
            fs        = FsType;
        end
        else if (hdr_opt == SyncByte)
        begin
            hdr_len_h = hdr_type;
            hdr_len_l = hdr_crc;
            fs        = FsOpt;
        end
        else if (hdr_type == SyncByte)
        begin
            hdr_len_h = hdr_crc;
            fs        = FsLenL;
        end
        else if (hdr_crc == SyncByte)
            fs = FsLenH;
        else
            fs = FsSync;
    endtask

    // Works out the characters that one received byte gives rise to.
    task automatic predict_rx_byte(input logic [7:0] b);
        logic last;
        if (!mdl_binary)
        begin
            if (b == CharLf)
                owe_char(8'h00, 1'b0, 1'b1);
            else if (b != CharCr)
                owe_char(b, 1'b1, 1'b0);
        end
        else
        begin
            case (fs)
                FsLenH:
                begin
                    hdr_len_h = b;
                    fs        = FsLenL;
                end
                FsLenL:
                begin
                    hdr_len_l = b;
                    fs        = FsOpt;
                end
                FsOpt:
                begin
                    hdr_opt = b;
                    fs      = FsType;
                end
                FsType:
                begin
                    hdr_type = b;
                    fs       = FsCheck;
                end
                FsCheck:
                begin
                    hdr_crc = b;
                    judge_header();
                end
                FsPayload:
                begin
                    payload_seen = payload_seen + 17'd1;
                    last = ({1'b0, payload_seen} >= {1'b0, payload_due} + 18'd1);
                    owe_hex_pair(b, last);
                    if (last)
                        fs = FsSync;
                end
                default:
                    fs = (b == SyncByte) ? FsLenH : FsSync;
            endcase
        end
    endtask

    // Character checker: every transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch("character with nothing expected", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_chars.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch("out_char", int'(m_axis_tdata), int'(want.ch));
                if (m_axis_tuser !== want.valid)
                    report_mismatch("char_valid", int'(m_axis_tuser), int'(want.valid));
                if (m_axis_tlast !== want.eom)
                    report_mismatch("end_of_message", int'(m_axis_tlast), int'(want.eom));
            end
        end
    end

    // Sends one byte, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        predict_rx_byte(b);
        sent_items++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds the sender until every owed character has come, then lets the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SettleTicks) @(posedge clk);
    endtask

    task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == AddrMode)
            mdl_binary = data[0];
        @(posedge clk);
    endtask

    // Reads the mode register back and compares it with the model.
    task automatic mode_readback();
        logic [DataW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrMode;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(DataW-1){1'b0}}, mdl_binary})
            report_mismatch("binary_mode readback", int'(got), int'(mdl_binary));
        @(posedge clk);
    endtask

    task automatic set_mode(input logic binary);
        wait_drained();
        reg_write(AddrMode, {{(DataW-1){1'b0}}, binary});
        mode_readback();
    endtask

    // A packet framed as on the link; a corrupted one carries a wrong header check byte.
    task automatic send_packet(input logic [7:0] dh, input logic [7:0] dl, input logic [7:0] ol,
                               input bit corrupt);
        logic [7:0] typ;
        logic [7:0] chk;
        int         n;
        typ = 8'($urandom_range(0, 255));
        chk = header_crc(dh, dl, ol, typ);
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(SyncByte);
        send_byte(dh);
        send_byte(dl);
        send_byte(ol);
        send_byte(typ);
        send_byte(chk);
        if (!corrupt)
        begin
            n = {dh, dl} + ol + 1;
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Line mode: plain bytes, a carriage return and a line feed, both byte extremes.
    task automatic test_line_mode();
        set_mode(1'b0);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(CharCr);
        send_byte(CharLf);
        send_byte(8'hFF);
    endtask

    // The shortest packet: empty data and optional parts, check byte only.
    task automatic test_min_packet();
        set_mode(1'b1);
        send_packet(8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // A bad header holding sync bytes: the machine must restart on the earliest one.
    task automatic test_header_resync();
        send_byte(SyncByte);
        send_byte(SyncByte);
        send_byte(8'h01);
        send_byte(SyncByte);
        send_byte(8'h02);
        send_byte(8'hAA);
    endtask

    // Framing survives a detour through line mode and a write to an unused address.
    task automatic test_mode_switch();
        logic [7:0] chk;
        wait_drained();
        send_byte(8'h00);
        send_byte(SyncByte);
        send_byte(8'h00);
        set_mode(1'b0);
        send_byte(8'h7A);
        send_byte(CharLf);
        set_mode(1'b1);
        reg_write(AddrSpare, '0);
        mode_readback();
        chk = header_crc(8'h00, 8'h01, 8'h00, 8'h0A);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h0A);
        send_byte(chk);
        send_byte(8'hFF);
        send_byte(SyncByte);
    endtask

    // One packet well beyond the lengths of the random traffic, with optional data.
    task automatic test_long_packet();
        wait_drained();
        send_packet(8'h00, 8'h50, 8'h0F, 1'b0);
    endtask

    // Mostly well-formed packets with random content, plus corrupt headers,
    // noise and bursts of line-mode text.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int start;
        int pick;
        int dlen;
        int olen;
        wait_drained();
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start          = sent_items;
        while (sent_items - start < n)
        begin
            pick = $urandom_range(0, 99);
            dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            olen = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            if (pick < 66)
                send_packet(8'h00, 8'(dlen), 8'(olen), 1'b0);
            else if (pick < 80)
                send_packet(8'h00, 8'(dlen), 8'(olen), 1'b1);
            else if (pick < 88)
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(0, 3) == 0) ? SyncByte
                                                          : 8'($urandom_range(0, 255)));
            else if (pick < 96)
            begin
                set_mode(1'b0);
                repeat ($urandom_range(3, 10))
                begin
                    pick = $urandom_range(0, 9);
                    send_byte(pick == 0 ? CharCr
                                        : pick == 1 ? CharLf : 8'($urandom_range(0, 255)));
                end
                set_mode(1'b1);
            end
            else
                wait_drained();
        end
    endtask

    // Test sequence.
    initial
    begin
        mdl_binary = 1'b1;
        fs         = FsSync;
        hdr_len_h  = '0;
        hdr_len_l  = '0;
        hdr_opt    = '0;
        hdr_type   = '0;
        hdr_crc    = '0;
        payload_seen = '0;
        payload_due  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        mode_readback();

        test_line_mode();
        test_min_packet();
        test_header_resync();
        test_mode_switch();
        test_long_packet();
        test_random_traffic(0, 0, 20);
        test_random_traffic(82, 0, 20);
        test_random_traffic(0, 82, 20);
        test_random_traffic(37, 37, 20);

        wait_drained();
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
